### rtl/core/float_to_decimal_ascii_defines.svh
// Assertion macros shared by the float to decimal text converter.
`ifndef FLOAT_TO_DECIMAL_ASCII_DEFINES_SVH
`define FLOAT_TO_DECIMAL_ASCII_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define FTD_ASSERT_IMPL(name, clk_s, rstn_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("implication check failed");
// Next-cycle implication, disabled while reset is asserted.
`define FTD_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define FTD_ASSERT_IMPL(name, clk_s, rstn_s, ante, cons)
`define FTD_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons)
`endif
`endif

### rtl/core/ftd_pkg.sv
// Shared constants and control types for the float to decimal text converter.
package ftd_pkg;

    localparam int MantBits  = 24;
    localparam int IntBits   = 31;
    localparam int FracBits  = 53;
    localparam int FixBits   = IntBits + FracBits;
    localparam int BcdDigits = 10;
    localparam int BcdBits   = 4 * BcdDigits;
    localparam int CntBits   = 5;

    localparam logic [7:0] CharMinus = 8'h2D;
    localparam logic [7:0] CharSpace = 8'h20;
    localparam logic [7:0] CharPoint = 8'h2E;
    localparam logic [7:0] CharZero  = 8'h30;
    localparam logic [7:0] CharNine  = 8'h39;

    localparam logic [3:0] MaxPlaces   = 4'd9;
    localparam logic [3:0] ResetPlaces = 4'd6;

    // Exponents at or above this saturate; below the other there is nothing to show.
    localparam logic [7:0] ExpSat     = 8'd158;
    localparam logic [7:0] ExpFracMin = 8'd97;

    localparam logic [IntBits-1:0]  SatInt    = {IntBits{1'b1}};
    localparam logic [CntBits-1:0]  ConvLast  = CntBits'(IntBits - 1);
    localparam logic [CntBits-1:0]  DigitsAll = CntBits'(BcdDigits);
    localparam logic [CntBits-1:0]  CntOne    = CntBits'(1);

    typedef struct packed {
        logic load;
        logic dabble;
        logic shift_digit;
    } bcd_ctrl_t;

    typedef struct packed {
        logic load;
        logic step;
    } frac_ctrl_t;

endpackage

### rtl/core/ftd_bcd.sv
// Bit-serial binary to BCD converter for the integer part, with digit shift-out.
module ftd_bcd (
    input  logic                       clk,
    input  ftd_pkg::bcd_ctrl_t         ctrl,
    input  logic [ftd_pkg::IntBits-1:0] ipart,
    output logic [3:0]                 top_digit
);
    import ftd_pkg::*;

    logic [IntBits-1:0] bin_reg;
    logic [IntBits-1:0] bin_next;
    logic [BcdBits-1:0] bcd_reg;
    logic [BcdBits-1:0] bcd_next;
    logic [BcdBits-1:0] bcd_adj;

    always_comb
    begin
        for (int i = 0; i < BcdDigits; i++)
        begin
            bcd_adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ?
                                bcd_reg[4*i +: 4] + 4'd3 : bcd_reg[4*i +: 4];
        end
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        if (ctrl.load)
        begin
            bin_next = ipart;
            bcd_next = '0;
        end
        else if (ctrl.dabble)
        begin
            // Each cycle moves one binary bit, most significant first, into the BCD word.
            bin_next = {bin_reg[IntBits-2:0], 1'b0};
            bcd_next = {bcd_adj[BcdBits-2:0], bin_reg[IntBits-1]};
        end
        else if (ctrl.shift_digit)
        begin
            bcd_next = {bcd_reg[BcdBits-5:0], 4'd0};
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign top_digit = bcd_reg[BcdBits-1 -: 4];

endmodule

### rtl/core/ftd_frac.sv
// Fraction digit generator: multiplies the binary fraction by ten once per digit.
module ftd_frac (
    input  logic                         clk,
    input  ftd_pkg::frac_ctrl_t          ctrl,
    input  logic [ftd_pkg::FracBits-1:0] fpart,
    output logic [3:0]                   digit
);
    import ftd_pkg::*;

    logic [FracBits-1:0] frac_reg;
    logic [FracBits-1:0] frac_next;
    logic [FracBits+3:0] prod;

    // Times ten as eight times plus two times; the bits above the point are the digit.
    assign prod  = {1'b0, frac_reg, 3'b000} + {3'b000, frac_reg, 1'b0};
    assign digit = prod[FracBits+3 -: 4];

    always_comb
    begin
        frac_next = frac_reg;
        if (ctrl.load)
        begin
            frac_next = fpart;
        end
        else if (ctrl.step)
        begin
            frac_next = prod[FracBits-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        frac_reg <= frac_next;
    end

endmodule

### rtl/core/float_to_decimal_ascii.sv
// Converts a single-precision float to fixed-point decimal text, one character per word.
//
// Input channel: float_bits with in_valid/in_ready; one value is taken while the block
// is idle. Output channel: char_code and last_char with out_valid/out_ready; one word
// per character: a sign ('-' or space), the integer digits without leading zeros, a
// '.', then decimal_places fraction digits (clamped to nine), last_char on the final.
// Configuration: decimal_places is written whenever decimal_places_we is high; write it
// only between values. Reset value is six places.
// Sequence: after a value is taken, its integer part is shifted bit by bit into BCD,
// then leading zero digits are dropped, then one character leaves per cycle while the
// receiver keeps out_ready high. The integer conversion loop is the longest phase of a
// value; a new value is taken only once the last character has been loaded.
// A stalled receiver holds the output register and the sequencer waits; nothing is lost.
// Reset clears the sequencer and output valid; no clearing pass is needed.
`include "float_to_decimal_ascii_defines.svh"
module float_to_decimal_ascii (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] float_bits,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  char_code,
    output logic        last_char,
    input  logic        decimal_places_we,
    input  logic [3:0]  decimal_places
);
    import ftd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_INT,
        ST_POINT,
        ST_FRAC
    } state_t;

    state_t              state_reg;
    logic [CntBits-1:0]  cnt_reg;
    logic                neg_reg;
    logic                out_valid_reg;
    logic [7:0]          char_reg;
    logic                last_reg;
    logic [3:0]          places_reg;

    logic                accept;
    logic                out_free;
    logic                emit;
    logic [3:0]          places;
    logic [7:0]          exp_f;
    logic [MantBits-1:0] mant;
    logic [7:0]          exp_eff;
    logic [7:0]          exp_off;
    logic [5:0]          shamt;
    logic [FixBits-1:0]  fixed;
    logic [IntBits-1:0]  ipart;
    logic [FracBits-1:0] fpart;
    logic                is_nan;
    logic                neg;
    logic [3:0]          int_digit;
    logic [3:0]          frac_digit;
    logic                char_ok;
    logic                sign_char;
    bcd_ctrl_t           bcd_ctrl;
    frac_ctrl_t          frac_ctrl;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    // A character is loaded into the output register this cycle.
    assign emit      = out_free && ((state_reg == ST_SIGN) || (state_reg == ST_INT)
                                    || (state_reg == ST_POINT) || (state_reg == ST_FRAC));
    assign places    = (places_reg > MaxPlaces) ? MaxPlaces : places_reg;
    assign out_valid = out_valid_reg;
    assign char_code = char_reg;
    assign last_char = last_reg;

    // Decode the float into a 31-bit integer part and a 53-bit binary fraction.
    always_comb
    begin
        exp_f   = float_bits[30:23];
        mant    = {exp_f != 8'd0, float_bits[22:0]};
        exp_eff = (exp_f == 8'd0) ? 8'd1 : exp_f;
        exp_off = exp_eff - ExpFracMin;
        shamt   = exp_off[5:0];
        fixed   = {{(FixBits-MantBits){1'b0}}, mant} << shamt;
        is_nan  = (exp_f == 8'hFF) && (float_bits[22:0] != 23'd0);
        neg     = float_bits[31] && (float_bits[30:0] != 31'd0) && !is_nan;
        if (exp_f >= ExpSat)
        begin
            ipart = SatInt;
            fpart = '0;
        end
        else if (exp_eff < ExpFracMin)
        begin
            ipart = '0;
            fpart = '0;
        end
        else
        begin
            ipart = fixed[FixBits-1 -: IntBits];
            fpart = fixed[FracBits-1:0];
        end
    end

    always_comb
    begin
        bcd_ctrl.load        = accept;
        bcd_ctrl.dabble      = (state_reg == ST_CONV);
        bcd_ctrl.shift_digit = ((state_reg == ST_SKIP) && (int_digit == 4'd0)
                                && (cnt_reg > CntOne))
                               || ((state_reg == ST_INT) && out_free);
        frac_ctrl.load       = accept;
        frac_ctrl.step       = (state_reg == ST_FRAC) && out_free;
    end

    ftd_bcd u_bcd (
        .clk       (clk),
        .ctrl      (bcd_ctrl),
        .ipart     (ipart),
        .top_digit (int_digit)
    );

    ftd_frac u_frac (
        .clk   (clk),
        .ctrl  (frac_ctrl),
        .fpart (fpart),
        .digit (frac_digit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            places_reg <= ResetPlaces;
        end
        else if (decimal_places_we)
        begin
            places_reg <= decimal_places;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            char_reg      <= CharSpace;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !emit)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        neg_reg   <= neg;
                        cnt_reg   <= '0;
                        state_reg <= ST_CONV;
                    end
                end
                ST_CONV:
                begin
                    if (cnt_reg == ConvLast)
                    begin
                        cnt_reg   <= DigitsAll;
                        state_reg <= ST_SKIP;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CntOne;
                    end
                end
                ST_SKIP:
                begin
                    // Drop leading zeros but always keep the units digit.
                    if ((int_digit == 4'd0) && (cnt_reg > CntOne))
                    begin
                        cnt_reg <= cnt_reg - CntOne;
                    end
                    else
                    begin
                        state_reg <= ST_SIGN;
                    end
                end
                ST_SIGN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        char_reg      <= neg_reg ? CharMinus : CharSpace;
                        last_reg      <= 1'b0;
                        state_reg     <= ST_INT;
                    end
                end
                ST_INT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        char_reg      <= CharZero + {4'd0, int_digit};
                        last_reg      <= 1'b0;
                        cnt_reg       <= cnt_reg - CntOne;
                        if (cnt_reg == CntOne)
                        begin
                            state_reg <= ST_POINT;
                        end
                    end
                end
                ST_POINT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        char_reg      <= CharPoint;
                        last_reg      <= (places == 4'd0);
                        cnt_reg       <= {{(CntBits-4){1'b0}}, places};
                        state_reg     <= (places == 4'd0) ? ST_IDLE : ST_FRAC;
                    end
                end
                ST_FRAC:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        char_reg      <= CharZero + {4'd0, frac_digit};
                        last_reg      <= (cnt_reg == CntOne);
                        cnt_reg       <= cnt_reg - CntOne;
                        if (cnt_reg == CntOne)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign char_ok   = ((char_code >= CharZero) && (char_code <= CharNine))
                       || (char_code == CharMinus) || (char_code == CharSpace)
                       || (char_code == CharPoint);
    assign sign_char = (char_code == CharMinus) || (char_code == CharSpace);

    `FTD_ASSERT_NEXT(a_accept_starts_conv, clk, rst_n, accept, (state_reg == ST_CONV) && (cnt_reg == '0))
    `FTD_ASSERT_IMPL(a_conv_count_bound, clk, rst_n, state_reg == ST_CONV, cnt_reg <= ConvLast)
    `FTD_ASSERT_IMPL(a_char_legal, clk, rst_n, out_valid, char_ok)
    `FTD_ASSERT_IMPL(a_last_not_sign, clk, rst_n, out_valid && last_char, !sign_char)

endmodule
